// ----- rtl/cca_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cca_pkg
// Shared types, register indexes and reset values of the CSMA/CA access block.
// ----------------------------------------------------------------------------
package cca_pkg;

  // Field widths fixed by the tick and result formats
  localparam int RSSI_W     = 9;
  localparam int RAND_W     = 10;
  localparam int TICKS_W    = 10;
  localparam int EXP_W      = 4;
  localparam int ATT_W      = 3;
  localparam int MODE_W     = 2;
  localparam int DELAY_W    = 24;
  localparam int CNT_W      = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_BUSY_THR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SENSE_MODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIFS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CW_MIN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CW_MAX     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ATT    = 3'd6;

  // Sense modes; bit 1 set means sensing off
  localparam logic [MODE_W-1:0] SENSE_RSSI = 2'd0;
  localparam logic [MODE_W-1:0] SENSE_CAD  = 2'd1;

  // Outcome codes
  localparam logic OUTCOME_GRANT = 1'b0;
  localparam logic OUTCOME_DROP  = 1'b1;

  // Register reset values
  localparam logic signed [RSSI_W-1:0] RST_BUSY_THR = -9'sd95;
  localparam logic [MODE_W-1:0]        RST_SENSE    = SENSE_RSSI;
  localparam logic [TICKS_W-1:0]       RST_DIFS     = 10'd30;
  localparam logic [TICKS_W-1:0]       RST_SLOT     = 10'd20;
  localparam logic [EXP_W-1:0]         RST_CW_MIN   = 4'd2;
  localparam logic [EXP_W-1:0]         RST_CW_MAX   = 4'd6;
  localparam logic [ATT_W-1:0]         RST_MAX_ATT  = 3'd5;

  // Default parameter values
  localparam int DEF_MAX_WINDOW_EXP = 10;
  localparam int DEF_TIMER_BITS     = 10;

  typedef struct packed {
    logic signed [RSSI_W-1:0] busy_thr;
    logic [MODE_W-1:0]        sense_mode;
    logic [TICKS_W-1:0]       difs_ticks;
    logic [TICKS_W-1:0]       slot_ticks;
    logic [EXP_W-1:0]         cw_min_exp;
    logic [EXP_W-1:0]         cw_max_exp;
    logic [ATT_W-1:0]         max_attempts;
  } cfg_t;

  typedef struct packed {
    logic                     action;
    logic signed [RSSI_W-1:0] rssi_dbm;
    logic                     cad_detected;
    logic [RAND_W-1:0]        random_bits;
  } item_t;

  typedef struct packed {
    logic               outcome;
    logic [CNT_W-1:0]   packet_seq;
    logic [ATT_W-1:0]   attempts_used;
    logic [DELAY_W-1:0] access_delay;
    logic [CNT_W-1:0]   sent_total;
    logic [CNT_W-1:0]   dropped_total;
    logic [CNT_W-1:0]   busy_total;
    logic [CNT_W-1:0]   delay_sum;
  } result_t;

endpackage

// ----- rtl/cca_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cca_if
// Valid/ready channels of the access block: tick input, result output and
// configuration writes.
// ----------------------------------------------------------------------------
interface cca_in_if import cca_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic signed [RSSI_W-1:0] rssi_dbm;
  logic                     cad_detected;
  logic [RAND_W-1:0]        random_bits;

  modport source (output valid, action, rssi_dbm, cad_detected, random_bits,
                  input ready);
  modport sink   (input valid, action, rssi_dbm, cad_detected, random_bits,
                  output ready);
endinterface

interface cca_out_if import cca_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               outcome;
  logic [CNT_W-1:0]   packet_seq;
  logic [ATT_W-1:0]   attempts_used;
  logic [DELAY_W-1:0] access_delay;
  logic [CNT_W-1:0]   sent_total;
  logic [CNT_W-1:0]   dropped_total;
  logic [CNT_W-1:0]   busy_total;
  logic [CNT_W-1:0]   delay_sum;

  modport source (output valid, outcome, packet_seq, attempts_used, access_delay,
                  sent_total, dropped_total, busy_total, delay_sum,
                  input ready);
  modport sink   (input valid, outcome, packet_seq, attempts_used, access_delay,
                  sent_total, dropped_total, busy_total, delay_sum,
                  output ready);
endinterface

interface cca_cfg_if import cca_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/csma_ca_channel_access.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csma_ca_channel_access
// CSMA/CA channel access with binary exponential backoff, one tick per request.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   : one request per 1 ms tick; action flags a new packet, and every
//            tick carries an RSSI sample, a CAD flag and random bits.
//   out_o  : one result per grant or drop, with sequence, attempts used,
//            access delay and the running totals after that result.
//   cfg_i  : register writes, always ready; write only while the block idles.
// Path: a tick is held in the input register and evaluated out of it once
//   the output register can take its result, which, if any, is loaded into it.
// Throughput: one tick per cycle unless out_o stalls; the access state machine
//   and counters take one compare/increment pass on the registered tick.
// Stall: while a result waits in the output register, one more tick may sit
//   in the input register; in_i.ready drops only when both are full.
// Reset: clears the state machine, counters and both register valids, and
//   loads the register defaults (threshold -95 dBm, RSSI mode, DIFS 30,
//   slot 20, window exponents 2 to 6, five attempts).
// ----------------------------------------------------------------------------
module csma_ca_channel_access import cca_pkg::*; #(
  parameter int MAX_WINDOW_EXP = DEF_MAX_WINDOW_EXP,
  parameter int TIMER_BITS     = DEF_TIMER_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cca_in_if.sink     in_i,
  cca_out_if.source  out_o,
  cca_cfg_if.sink    cfg_i
);

  cfg_t    cfg;
  item_t   item_q;
  logic    item_valid_q;
  result_t res, res_q;
  logic    res_valid;
  logic    out_valid_q;
  logic    advance;

  cca_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Evaluate the held tick once the output register can take its result
  assign advance    = item_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !item_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      item_valid_q <= in_i.valid;
    end
  end

  // Payload register: capture on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.action       <= in_i.action;
      item_q.rssi_dbm     <= in_i.rssi_dbm;
      item_q.cad_detected <= in_i.cad_detected;
      item_q.random_bits  <= in_i.random_bits;
    end
  end

  cca_core #(
    .MAX_WINDOW_EXP (MAX_WINDOW_EXP),
    .TIMER_BITS     (TIMER_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .item_i      (item_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register: load a new result, or drop the taken one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      res_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.outcome       = res_q.outcome;
  assign out_o.packet_seq    = res_q.packet_seq;
  assign out_o.attempts_used = res_q.attempts_used;
  assign out_o.access_delay  = res_q.access_delay;
  assign out_o.sent_total    = res_q.sent_total;
  assign out_o.dropped_total = res_q.dropped_total;
  assign out_o.busy_total    = res_q.busy_total;
  assign out_o.delay_sum     = res_q.delay_sum;

endmodule

// ----- rtl/cca_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cca_cfg_regs
// Configuration register file, written one register per request.
// ----------------------------------------------------------------------------
module cca_cfg_regs import cca_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  cca_cfg_if.sink   cfg_i,
  output cfg_t      cfg_o
);

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.busy_thr     <= RST_BUSY_THR;
      cfg_q.sense_mode   <= RST_SENSE;
      cfg_q.difs_ticks   <= RST_DIFS;
      cfg_q.slot_ticks   <= RST_SLOT;
      cfg_q.cw_min_exp   <= RST_CW_MIN;
      cfg_q.cw_max_exp   <= RST_CW_MAX;
      cfg_q.max_attempts <= RST_MAX_ATT;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_BUSY_THR:   cfg_q.busy_thr     <= $signed(cfg_i.data[RSSI_W-1:0]);
        REG_SENSE_MODE: cfg_q.sense_mode   <= cfg_i.data[MODE_W-1:0];
        REG_DIFS:       cfg_q.difs_ticks   <= cfg_i.data[TICKS_W-1:0];
        REG_SLOT:       cfg_q.slot_ticks   <= cfg_i.data[TICKS_W-1:0];
        REG_CW_MIN:     cfg_q.cw_min_exp   <= cfg_i.data[EXP_W-1:0];
        REG_CW_MAX:     cfg_q.cw_max_exp   <= cfg_i.data[EXP_W-1:0];
        REG_MAX_ATT:    cfg_q.max_attempts <= cfg_i.data[ATT_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

endmodule

// ----- rtl/cca_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cca_core
// Access state machine and statistics counters; one tick per enabled cycle.
// ----------------------------------------------------------------------------
module cca_core import cca_pkg::*; #(
  parameter int MAX_WINDOW_EXP = DEF_MAX_WINDOW_EXP,
  parameter int TIMER_BITS     = DEF_TIMER_BITS
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output logic    res_valid_o,
  output result_t res_o
);

  typedef enum logic [1:0] {
    PhIdle    = 2'd0,
    PhDifs    = 2'd1,
    PhBackoff = 2'd2
  } phase_e;

  localparam int TW = TIMER_BITS;
  localparam int MW = (TW > RAND_W) ? TW : RAND_W;     // slot draw width
  localparam int CW = (TW > TICKS_W) ? TW : TICKS_W;   // tick compare width
  localparam logic [TW-1:0]      TIMER_MAX = {TW{1'b1}};
  localparam logic [DELAY_W-1:0] DELAY_MAX = {DELAY_W{1'b1}};
  localparam logic [EXP_W:0]     WIN_CAP   = (EXP_W+1)'(MAX_WINDOW_EXP);

  phase_e             phase_q, phase_d;
  logic [ATT_W-1:0]   attempt_q, attempt_d;
  logic [EXP_W-1:0]   window_q, window_d;
  logic [TW-1:0]      slots_q, slots_d;
  logic [TW-1:0]      free_q, free_d;
  logic [DELAY_W-1:0] elapsed_q, elapsed_d;
  logic [CNT_W-1:0]   seq_q, seq_d;
  logic [CNT_W-1:0]   sent_q, sent_d;
  logic [CNT_W-1:0]   dropped_q, dropped_d;
  logic [CNT_W-1:0]   busy_q, busy_d;
  logic [CNT_W-1:0]   delay_q, delay_d;

  logic             busy, off;
  logic [CW-1:0]    need_difs, need_slot;
  logic [ATT_W-1:0] eff_att;
  logic [EXP_W-1:0] init_window;

  always_comb begin
    case (cfg_i.sense_mode)
      SENSE_RSSI: busy = item_i.rssi_dbm > cfg_i.busy_thr;
      SENSE_CAD:  busy = item_i.cad_detected;
      default:    busy = 1'b0;
    endcase
  end

  assign off         = cfg_i.sense_mode[1];
  assign need_difs   = CW'((cfg_i.difs_ticks == '0) ? TICKS_W'(1) : cfg_i.difs_ticks);
  assign need_slot   = CW'((cfg_i.slot_ticks == '0) ? TICKS_W'(1) : cfg_i.slot_ticks);
  assign eff_att     = (cfg_i.max_attempts == '0) ? ATT_W'(1) : cfg_i.max_attempts;
  assign init_window = ({1'b0, cfg_i.cw_min_exp} > WIN_CAP) ? EXP_W'(WIN_CAP)
                                                            : cfg_i.cw_min_exp;

  always_comb begin
    logic          go, grant, drop, end_bo;
    logic [TW-1:0] free_nx;
    logic [MW-1:0] rnd_ext, draw;
    logic [EXP_W:0] win_nx;

    phase_d   = phase_q;
    attempt_d = attempt_q;
    window_d  = window_q;
    slots_d   = slots_q;
    free_d    = free_q;
    elapsed_d = elapsed_q;
    seq_d     = seq_q;
    sent_d    = sent_q;
    dropped_d = dropped_q;
    busy_d    = busy_q;
    delay_d   = delay_q;
    go        = 1'b0;
    grant     = 1'b0;
    drop      = 1'b0;
    end_bo    = 1'b0;
    free_nx   = (free_q != TIMER_MAX) ? free_q + 1'b1 : free_q;
    rnd_ext   = MW'(item_i.random_bits);
    draw      = '0;
    win_nx    = '0;

    // Start a packet on a request from idle, otherwise age the one in flight
    if (phase_q == PhIdle) begin
      if (item_i.action) begin
        go        = 1'b1;
        phase_d   = PhDifs;
        attempt_d = ATT_W'(1);
        window_d  = init_window;
        slots_d   = '0;
        free_d    = '0;
        elapsed_d = '0;
        free_nx   = TW'(1);
      end
    end else begin
      go = 1'b1;
      if (elapsed_q != DELAY_MAX) elapsed_d = elapsed_q + 1'b1;
    end

    if (go) begin
      unique case (phase_d)
        PhDifs: begin
          if (off) begin
            grant = 1'b1;
          end else if (busy) begin
            busy_d = busy_q + 1'b1;
            for (int i = 0; i < MW; i++) begin
              draw[i] = rnd_ext[i] & (i < int'(window_d)) & (i < TW);
            end
            slots_d = TW'(draw);
            free_d  = '0;
            if (slots_d == '0) end_bo = 1'b1;
            else               phase_d = PhBackoff;
          end else begin
            free_d = free_nx;
            if (CW'(free_nx) >= need_difs) grant = 1'b1;
          end
        end
        PhBackoff: begin
          if (off || slots_d == '0) begin
            end_bo = 1'b1;
          end else if (busy) begin
            free_d = '0;   // freeze: restart the slot
          end else if (CW'(free_nx) >= need_slot) begin
            free_d  = '0;
            slots_d = slots_d - 1'b1;
            if (slots_d == '0) end_bo = 1'b1;
          end else begin
            free_d = free_nx;
          end
        end
        default: phase_d = PhIdle;
      endcase
    end

    // Widen the window and retry, or give up after the last attempt
    if (end_bo) begin
      win_nx = {1'b0, window_d} + 1'b1;
      if (win_nx > {1'b0, cfg_i.cw_max_exp}) win_nx = {1'b0, cfg_i.cw_max_exp};
      if (win_nx > WIN_CAP) win_nx = WIN_CAP;
      window_d = EXP_W'(win_nx);
      slots_d  = '0;
      free_d   = '0;
      if (attempt_d >= eff_att) begin
        drop = 1'b1;
      end else begin
        attempt_d = attempt_d + 1'b1;
        phase_d   = PhDifs;
      end
    end

    res_o.outcome       = drop ? OUTCOME_DROP : OUTCOME_GRANT;
    res_o.packet_seq    = seq_q;
    res_o.attempts_used = drop ? eff_att : attempt_d;
    res_o.access_delay  = elapsed_d;
    if (grant) begin
      sent_d  = sent_q + 1'b1;
      delay_d = delay_q + CNT_W'(elapsed_d);
    end
    if (drop) dropped_d = dropped_q + 1'b1;
    if (grant || drop) begin
      seq_d   = seq_q + 1'b1;
      phase_d = PhIdle;
      free_d  = '0;
      slots_d = '0;
    end
    res_o.sent_total    = sent_d;
    res_o.dropped_total = dropped_d;
    res_o.busy_total    = busy_d;
    res_o.delay_sum     = delay_d;
    res_valid_o         = grant || drop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      attempt_q <= '0;
      window_q  <= '0;
      slots_q   <= '0;
      free_q    <= '0;
      elapsed_q <= '0;
      seq_q     <= '0;
      sent_q    <= '0;
      dropped_q <= '0;
      busy_q    <= '0;
      delay_q   <= '0;
    end else if (en_i) begin
      phase_q   <= phase_d;
      attempt_q <= attempt_d;
      window_q  <= window_d;
      slots_q   <= slots_d;
      free_q    <= free_d;
      elapsed_q <= elapsed_d;
      seq_q     <= seq_d;
      sent_q    <= sent_d;
      dropped_q <= dropped_d;
      busy_q    <= busy_d;
      delay_q   <= delay_d;
    end
  end

endmodule

// ----- rtl/cca_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cca_checker
// Port-level checks on the result stream of the access block.
// ----------------------------------------------------------------------------
module cca_checker import cca_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic               outcome_i,
  input logic [CNT_W-1:0]   packet_seq_i,
  input logic [DELAY_W-1:0] access_delay_i,
  input logic [CNT_W-1:0]   sent_total_i,
  input logic [CNT_W-1:0]   dropped_total_i,
  input logic [CNT_W-1:0]   delay_sum_i
);

  logic             out_acc;
  logic [CNT_W-1:0] seq_q, sent_q, dropped_q, sum_q;

  assign out_acc = out_valid_i && out_ready_i;

  // Track the last result taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q     <= '1;
      sent_q    <= '0;
      dropped_q <= '0;
      sum_q     <= '0;
    end else if (out_acc) begin
      seq_q     <= packet_seq_i;
      sent_q    <= sent_total_i;
      dropped_q <= dropped_total_i;
      sum_q     <= delay_sum_i;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(packet_seq_i)
                                    && $stable(outcome_i) && $stable(sent_total_i))
    else $error("result changed while stalled");

  a_seq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> packet_seq_i == seq_q + 1'b1)
    else $error("packet sequence skipped or repeated");

  a_grant_totals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && outcome_i == OUTCOME_GRANT |->
      sent_total_i == sent_q + 1'b1 && dropped_total_i == dropped_q
      && delay_sum_i == sum_q + CNT_W'(access_delay_i))
    else $error("grant totals inconsistent");

  a_drop_totals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && outcome_i == OUTCOME_DROP |->
      dropped_total_i == dropped_q + 1'b1 && sent_total_i == sent_q
      && delay_sum_i == sum_q)
    else $error("drop totals inconsistent");

endmodule

bind csma_ca_channel_access cca_checker u_cca_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .outcome_i       (out_o.outcome),
  .packet_seq_i    (out_o.packet_seq),
  .access_delay_i  (out_o.access_delay),
  .sent_total_i    (out_o.sent_total),
  .dropped_total_i (out_o.dropped_total),
  .delay_sum_i     (out_o.delay_sum)
);
